>>> rtl/core/scs_pkg.sv
// Package for the spectral channel statistics core.
// Holds field widths, status and command codes, and the control/status structs.
// No dependencies.
`default_nettype none

package scs_pkg;

   // Fixed field widths.
   localparam int unsigned CHAN_WIDTH  = 4;
   localparam int unsigned CNT_WIDTH   = 25;
   localparam int unsigned SUM_WIDTH   = 32;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned GAIN_WIDTH  = 4;
   localparam int unsigned CSR_WIDTH   = 16;
   localparam int unsigned STEP_WIDTH  = 5;

   // Gain codes above this value saturate.
   localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = 4'd10;

   // Register reset values.
   localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 4'd7;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 16'd64;

   // Register indexes on the configuration port.
   localparam logic REG_GAIN  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   // Input word commands.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_LIMIT = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;    // capture an accepted input word
      logic sample_upd;  // update one channel and load its result
      logic err_out;     // load the empty-report error result
      logic div_start;   // load the divider with the current channel's sum
      logic div_step;    // one quotient bit
      logic rep_out;     // write back the quotient and load the report result
   } scs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_report;
      logic chan_ok;
      logic count_zero;
      logic div_done;
      logic idx_last;
      logic out_free;
   } scs_stat_type;

endpackage : scs_pkg

`default_nettype wire

>>> rtl/core/scs_ctrl.sv
// Controller state machine for the spectral channel statistics core.
// Sequences sample updates and the per-channel report division; uses scs_pkg.
`default_nettype none

module scs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire scs_pkg::scs_stat_type stat,
   output scs_pkg::scs_cmd_type       cmd
);
   import scs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.is_report) begin
               // A word for a channel that does not exist is dropped.
               if (!stat.chan_ok) begin
                  state_in = S_IDLE;
               end else if (stat.out_free) begin
                  cmd.sample_upd = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (stat.count_zero) begin
               if (stat.out_free) begin
                  cmd.err_out = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.rep_out = 1'b1;
               state_in    = stat.idx_last ? S_IDLE : S_EXEC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule : scs_ctrl

`default_nettype wire

>>> rtl/core/scs_datapath.sv
// Datapath for the spectral channel statistics core: configuration registers,
// per-channel statistics, the shared restoring divider and the result register.
// Uses scs_pkg.
`default_nettype none

module scs_datapath #(
   parameter int unsigned CHANNELS  = 12,
   parameter int unsigned RAW_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_cmd,
   input  wire logic [scs_pkg::CHAN_WIDTH-1:0]    req_channel,
   input  wire logic [RAW_WIDTH-1:0]              req_raw_count,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_index,
   input  wire logic [scs_pkg::CSR_WIDTH-1:0]     csr_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [scs_pkg::CHAN_WIDTH-1:0]         rsp_out_channel,
   output logic [scs_pkg::CNT_WIDTH-1:0]          rsp_norm_count,
   output logic [scs_pkg::SUM_WIDTH-1:0]          rsp_average,
   output logic [scs_pkg::CNT_WIDTH-1:0]          rsp_minimum,
   output logic [scs_pkg::CNT_WIDTH-1:0]          rsp_maximum,
   output logic [1:0]                             rsp_status,
   output logic                                   rsp_last,
   input  wire scs_pkg::scs_cmd_type              cmd,
   output scs_pkg::scs_stat_type                  stat
);
   import scs_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Gain normalisation: half gain shifts right, otherwise left by code-1.
   function automatic logic [CNT_WIDTH-1:0] to_basic(
      input logic [RAW_WIDTH-1:0]  raw,
      input logic [GAIN_WIDTH-1:0] gain
   );
      logic [GAIN_WIDTH-1:0] g;
      logic [CNT_WIDTH-1:0]  r;
      g = (gain > GAIN_MAX) ? GAIN_MAX : gain;
      r = CNT_WIDTH'(raw);
      if (g == '0) begin
         return r >> 1;
      end
      return r << (g - GAIN_WIDTH'(1));
   endfunction

   logic [GAIN_WIDTH-1:0]  gain_ff;
   logic [COUNT_WIDTH-1:0] limit_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   is_report_ff;
   logic [CHAN_WIDTH-1:0]  chan_ff;
   logic [CNT_WIDTH-1:0]   basic_ff;
   logic [IDX_W-1:0]       rep_idx_ff;

   logic [CNT_WIDTH-1:0]   min_ff [CHANNELS];
   logic [CNT_WIDTH-1:0]   max_ff [CHANNELS];
   logic [SUM_WIDTH-1:0]   sum_ff [CHANNELS];

   logic [SUM_WIDTH-1:0]   quo_ff;
   logic [COUNT_WIDTH-1:0] rem_ff;
   logic [STEP_WIDTH-1:0]  step_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [CHAN_WIDTH-1:0]  out_chan_ff;
   logic [CNT_WIDTH-1:0]   out_basic_ff;
   logic [SUM_WIDTH-1:0]   out_avg_ff;
   logic [CNT_WIDTH-1:0]   out_min_ff;
   logic [CNT_WIDTH-1:0]   out_max_ff;
   status_type             out_status_ff;
   logic                   out_last_ff;

   logic [IDX_W-1:0]       rd_idx;
   logic [CNT_WIDTH-1:0]   rd_min, rd_max, min_in, max_in;
   logic [SUM_WIDTH-1:0]   rd_sum, sum_in;
   logic                   limit_hit;
   logic [COUNT_WIDTH:0]   partial;
   logic [COUNT_WIDTH-1:0] diff;
   logic                   quo_bit;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_GAIN) begin
            gain_ff <= csr_wdata[GAIN_WIDTH-1:0];
         end else begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Captured input word; the basic count is formed on the way in.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_report_ff <= (req_cmd == CMD_REPORT);
         chan_ff      <= req_channel;
         basic_ff     <= to_basic(req_raw_count, gain_ff);
      end
   end

   // Report channel counter.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rep_idx_ff <= '0;
      end else if (cmd.rep_out && !stat.idx_last) begin
         rep_idx_ff <= rep_idx_ff + IDX_W'(1);
      end
   end

   // One read address serves both the sample update and the report sweep.
   assign rd_idx = is_report_ff ? rep_idx_ff : chan_ff[IDX_W-1:0];
   assign rd_min = min_ff[rd_idx];
   assign rd_max = max_ff[rd_idx];
   assign rd_sum = sum_ff[rd_idx];

   // Sample update of one channel.
   assign limit_hit = (count_ff >= limit_ff);
   assign min_in    = (basic_ff < rd_min) ? basic_ff : rd_min;
   assign max_in    = (basic_ff > rd_max) ? basic_ff : rd_max;
   assign sum_in    = limit_hit ? rd_sum : rd_sum + SUM_WIDTH'(basic_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.sample_upd && !limit_hit && (chan_ff == CHAN_WIDTH'(CHANNELS - 1))) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   // Per-channel statistics and the sample counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= '1;
            max_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.sample_upd) begin
            min_ff[rd_idx] <= min_in;
            max_ff[rd_idx] <= max_in;
            sum_ff[rd_idx] <= sum_in;
         end else if (cmd.rep_out) begin
            sum_ff[rd_idx] <= quo_ff;
         end
      end
   end

   // Restoring divider, one quotient bit a cycle, dividend shifted out of quo_ff.
   // When the divisor fits, the difference is below it and so fits the remainder.
   assign partial = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign quo_bit = (partial >= {1'b0, count_ff});
   assign diff    = partial[COUNT_WIDTH-1:0] - count_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= rd_sum;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_WIDTH-2:0], quo_bit};
         rem_ff  <= quo_bit ? diff : partial[COUNT_WIDTH-1:0];
         step_ff <= step_ff + STEP_WIDTH'(1);
      end
   end

   // Result register; it holds a word until the consumer takes it.
   assign out_valid_in = (cmd.sample_upd || cmd.err_out || cmd.rep_out) ? 1'b1 :
                         (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_upd) begin
         out_chan_ff   <= chan_ff;
         out_basic_ff  <= basic_ff;
         out_avg_ff    <= sum_in;
         out_min_ff    <= min_in;
         out_max_ff    <= max_in;
         out_status_ff <= limit_hit ? ST_LIMIT : ST_OK;
         out_last_ff   <= 1'b1;
      end else if (cmd.err_out) begin
         out_chan_ff   <= '0;
         out_basic_ff  <= '0;
         out_avg_ff    <= '0;
         out_min_ff    <= '0;
         out_max_ff    <= '0;
         out_status_ff <= ST_EMPTY;
         out_last_ff   <= 1'b1;
      end else if (cmd.rep_out) begin
         out_chan_ff   <= CHAN_WIDTH'(rep_idx_ff);
         out_basic_ff  <= '0;
         out_avg_ff    <= quo_ff;
         out_min_ff    <= rd_min;
         out_max_ff    <= rd_max;
         out_status_ff <= ST_OK;
         out_last_ff   <= stat.idx_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_channel = out_chan_ff;
   assign rsp_norm_count  = out_basic_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_minimum     = out_min_ff;
   assign rsp_maximum     = out_max_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last        = out_last_ff;

   // Status to the controller.
   assign stat.is_report  = is_report_ff;
   assign stat.chan_ok    = ({1'b0, chan_ff} < (CHAN_WIDTH + 1)'(CHANNELS));
   assign stat.count_zero = (count_ff == '0);
   assign stat.div_done   = (step_ff == '1);
   assign stat.idx_last   = (rep_idx_ff == IDX_W'(CHANNELS - 1));
   assign stat.out_free   = !out_valid_ff || rsp_ready;

endmodule : scs_datapath

`default_nettype wire

>>> rtl/core/spectral_channel_statistics_core.sv
// Top level of the spectral channel statistics core; joins scs_ctrl and scs_datapath, uses scs_pkg.
// A sample word is captured on acceptance and updates its channel once the result register is
// free, loading its result then; no new word is taken until that update is done.
// A report handles each channel in turn with one load, 32 divider steps and one write-back,
// and an empty report gives only its error word. A stalled result holds the sequence.
// Synchronous active-high reset clears the statistics and loads gain 7, limit 64.
`default_nettype none

module spectral_channel_statistics_core #(
   parameter int unsigned CHANNELS  = 12,
   parameter int unsigned RAW_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [scs_pkg::CHAN_WIDTH-1:0] req_channel,
   input  wire logic [RAW_WIDTH-1:0]           req_raw_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [scs_pkg::CHAN_WIDTH-1:0]      rsp_out_channel,
   output logic [scs_pkg::CNT_WIDTH-1:0]       rsp_norm_count,
   output logic [scs_pkg::SUM_WIDTH-1:0]       rsp_average,
   output logic [scs_pkg::CNT_WIDTH-1:0]       rsp_minimum,
   output logic [scs_pkg::CNT_WIDTH-1:0]       rsp_maximum,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [scs_pkg::CSR_WIDTH-1:0]  csr_wdata
);
   import scs_pkg::*;

   scs_cmd_type  cmd;
   scs_stat_type stat;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scs_datapath #(
      .CHANNELS  (CHANNELS),
      .RAW_WIDTH (RAW_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_channel     (req_channel),
      .req_raw_count   (req_raw_count),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_norm_count  (rsp_norm_count),
      .rsp_average     (rsp_average),
      .rsp_minimum     (rsp_minimum),
      .rsp_maximum     (rsp_maximum),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .stat            (stat)
   );

`ifndef NO_ASSERTIONS
   // A result is only loaded when the result register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.sample_upd || cmd.err_out || cmd.rep_out) |-> stat.out_free)
      else $error("result loaded over a pending word");

   // A sample update only happens for an existing channel.
   a_sample_chan: assert property (@(posedge clock) disable iff (reset)
      cmd.sample_upd |-> (stat.chan_ok && !stat.is_report))
      else $error("sample update for a channel out of range");

   // The error result is only produced for a report with no samples.
   a_err_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.err_out |-> (stat.is_report && stat.count_zero))
      else $error("error result without an empty report");

   // A sample that was not accumulated still lies between its channel's bounds.
   a_limit_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_LIMIT) |->
         (rsp_minimum <= rsp_norm_count && rsp_norm_count <= rsp_maximum && rsp_last))
      else $error("sample result outside its channel's bounds");
`endif

endmodule : spectral_channel_statistics_core

`default_nettype wire

>>> dv/spectral_channel_statistics_core_test.sv
// Self-checking testbench for spectral_channel_statistics_core.
// Uses scs_pkg for codes and widths. It predicts every result word from its
// own copy of the per-channel statistics and drives random handshake gaps.

module spectral_channel_statistics_core_test;
   import scs_pkg::*;

   localparam int NUM_CHANNELS = 12;
   localparam int RAW_BITS     = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_PAD   = 16;

   // One sensor word as offered on the request channel.
   typedef struct {
      logic                  cmd;
      logic [CHAN_WIDTH-1:0] chan;
      logic [RAW_BITS-1:0]   raw;
   } sensor_word_type;

   // One statistics word as it should appear on the result channel.
   typedef struct packed {
      logic [CHAN_WIDTH-1:0] chan;
      logic [CNT_WIDTH-1:0]  basic;
      logic [SUM_WIDTH-1:0]  avg;
      logic [CNT_WIDTH-1:0]  lo;
      logic [CNT_WIDTH-1:0]  hi;
      status_type            status;
      logic                  last;
   } stats_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = CMD_SAMPLE;
   logic [CHAN_WIDTH-1:0]  req_channel = '0;
   logic [RAW_BITS-1:0]    req_raw_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAN_WIDTH-1:0]  rsp_out_channel;
   logic [CNT_WIDTH-1:0]   rsp_norm_count;
   logic [SUM_WIDTH-1:0]   rsp_average;
   logic [CNT_WIDTH-1:0]   rsp_minimum;
   logic [CNT_WIDTH-1:0]   rsp_maximum;
   logic [1:0]             rsp_status;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = REG_GAIN;
   logic [CSR_WIDTH-1:0]   csr_wdata = '0;

   // Predicted statistics state and register copies.
   logic [CNT_WIDTH-1:0]   lo_seen [NUM_CHANNELS];
   logic [CNT_WIDTH-1:0]   hi_seen [NUM_CHANNELS];
   logic [SUM_WIDTH-1:0]   acc_sum [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] sweeps_closed;
   logic [GAIN_WIDTH-1:0]  gain_now;
   logic [COUNT_WIDTH-1:0] limit_now;

   sensor_word_type word_backlog [$];
   stats_word_type  stats_due [$];

   int  mismatches = 0;
   int  idle_run = 0;
   int  send_idle_pct = 22;
   int  recv_idle_pct = 66;
   int  hold_count = 0;
   bit  hold_armed = 1'b0;
   bit  req_took = 1'b0;

   spectral_channel_statistics_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_channel     (req_channel),
      .req_raw_count   (req_raw_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_norm_count  (rsp_norm_count),
      .rsp_average     (rsp_average),
      .rsp_minimum     (rsp_minimum),
      .rsp_maximum     (rsp_maximum),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gain normalisation: half gain shifts right, otherwise shift left by gain-1.
   function automatic logic [CNT_WIDTH-1:0] normalised(input logic [RAW_BITS-1:0] raw);
      logic [GAIN_WIDTH-1:0] g;
      logic [40:0]           wide;
      g = (gain_now > GAIN_MAX) ? GAIN_MAX : gain_now;
      if (g == 0) begin
         wide = {25'b0, raw} >> 1;
      end else begin
         wide = {25'b0, raw} << (g - GAIN_WIDTH'(1));
      end
      return wide[CNT_WIDTH-1:0];
   endfunction

   // Work out the result words that one accepted sensor word causes.
   task automatic predict_statistics(input logic cmd, input logic [CHAN_WIDTH-1:0] ch,
                                     input logic [RAW_BITS-1:0] raw);
      stats_word_type        w;
      logic [CNT_WIDTH-1:0]  basic;
      w = '0;
      if (cmd == CMD_SAMPLE) begin
         // Channels beyond the last one are dropped without a result.
         if (ch < NUM_CHANNELS) begin
            basic = normalised(raw);
            if (basic < lo_seen[ch]) lo_seen[ch] = basic;
            if (basic > hi_seen[ch]) hi_seen[ch] = basic;
            w.status = ST_OK;
            if (sweeps_closed >= limit_now) begin
               w.status = ST_LIMIT;
            end else begin
               acc_sum[ch] = acc_sum[ch] + SUM_WIDTH'(basic);
               if (ch == NUM_CHANNELS - 1) sweeps_closed = sweeps_closed + COUNT_WIDTH'(1);
            end
            w.chan  = ch;
            w.basic = basic;
            w.avg   = acc_sum[ch];
            w.lo    = lo_seen[ch];
            w.hi    = hi_seen[ch];
            w.last  = 1'b1;
            stats_due.push_back(w);
         end
      end else if (sweeps_closed == 0) begin
         // A report before any completed sweep gives one error word.
         w.status = ST_EMPTY;
         w.last   = 1'b1;
         stats_due.push_back(w);
      end else begin
         // The accumulators are divided in place, so repeated reports divide again.
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            acc_sum[i] = acc_sum[i] / {16'b0, sweeps_closed};
            w.chan   = i[CHAN_WIDTH-1:0];
            w.basic  = '0;
            w.avg    = acc_sum[i];
            w.lo     = lo_seen[i];
            w.hi     = hi_seen[i];
            w.status = ST_OK;
            w.last   = (i == NUM_CHANNELS - 1);
            stats_due.push_back(w);
         end
      end
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] seen,
                                input logic [31:0] wanted);
      mismatches++;
      $display("%0t: %s mismatch: got 0x%0h, wanted 0x%0h", $time, what, seen, wanted);
   endtask

   // Monitor: keeps the prediction in step with every handshake and checks results.
   always @(posedge clock) begin : monitor
      stats_word_type due;
      req_took = req_valid && req_ready;
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            lo_seen[i] = '1;
            hi_seen[i] = '0;
            acc_sum[i] = '0;
         end
         sweeps_closed = '0;
         gain_now      = GAIN_RESET;
         limit_now     = LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GAIN) begin
               gain_now = csr_wdata[GAIN_WIDTH-1:0];
            end else begin
               limit_now = csr_wdata[COUNT_WIDTH-1:0];
            end
         end
         if (req_took) predict_statistics(req_cmd, req_channel, req_raw_count);
         if (rsp_valid && rsp_ready) begin
            if (stats_due.size() == 0) begin
               note_mismatch("unrequested result word, channel", 32'(rsp_out_channel), '0);
            end else begin
               due = stats_due.pop_front();
               if (rsp_out_channel !== due.chan)
                  note_mismatch("out_channel", 32'(rsp_out_channel), 32'(due.chan));
               if (rsp_norm_count !== due.basic)
                  note_mismatch("norm_count", 32'(rsp_norm_count), 32'(due.basic));
               if (rsp_average !== due.avg)
                  note_mismatch("average", rsp_average, due.avg);
               if (rsp_minimum !== due.lo)
                  note_mismatch("minimum", 32'(rsp_minimum), 32'(due.lo));
               if (rsp_maximum !== due.hi)
                  note_mismatch("maximum", 32'(rsp_maximum), 32'(due.hi));
               if (rsp_status !== due.status)
                  note_mismatch("status", 32'(rsp_status), 32'(due.status));
               if (rsp_last !== due.last)
                  note_mismatch("last", 32'(rsp_last), 32'(due.last));
            end
         end
      end
   end

   // Driver: offers sensor words from the backlog, with random gaps between them.
   always @(negedge clock) begin : driver
      sensor_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = word_backlog.pop_front();
            req_valid     <= 1'b1;
            req_cmd       <= w.cmd;
            req_channel   <= w.chan;
            req_raw_count <= w.raw;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off once armed.
   always @(negedge clock) begin : receiver
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run if no handshake completes for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_run = 0;
      end else begin
         idle_run = idle_run + 1;
      end
      if (idle_run >= STALL_LIMIT) begin
         $display("spectral_channel_statistics_core regression: fail");
         $finish;
      end
   end

   task automatic push_word(input logic cmd, input logic [CHAN_WIDTH-1:0] ch,
                            input logic [RAW_BITS-1:0] raw);
      sensor_word_type w;
      w.cmd  = cmd;
      w.chan = ch;
      w.raw  = raw;
      word_backlog.push_back(w);
   endtask

   task automatic write_register(input logic idx, input logic [CSR_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Gain writes carry random upper bits, which the block must ignore.
   task automatic configure(input logic [GAIN_WIDTH-1:0] gain,
                            input logic [COUNT_WIDTH-1:0] lim);
      logic [CSR_WIDTH-1:0] data;
      data = CSR_WIDTH'($urandom);
      data[GAIN_WIDTH-1:0] = gain;
      write_register(REG_GAIN, data);
      write_register(REG_LIMIT, lim);
   endtask

   // Wait until every word is taken and answered, then let the block go quiet.
   task automatic settle();
      while (word_backlog.size() != 0 || req_valid) @(posedge clock);
      while (stats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   function automatic logic [RAW_BITS-1:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return RAW_BITS'($urandom_range(0, 15));
         3: return RAW_BITS'(1) << $urandom_range(0, RAW_BITS - 1);
         default: return RAW_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'd1;
         2: return COUNT_WIDTH'($urandom_range(2, 4));
         3: return '1;
         4: return COUNT_WIDTH'($urandom_range(5, 40));
         default: return COUNT_WIDTH'($urandom);
      endcase
   endfunction

   // Mostly full or partial channel sweeps, with reports, stray samples and noise.
   task automatic queue_random_words(input int count);
      int made;
      int pick;
      int first;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CHANNELS - 1) : 0;
            for (int ch = first; ch < NUM_CHANNELS; ch++) begin
               push_word(CMD_SAMPLE, CHAN_WIDTH'(ch), pick_raw());
               made++;
            end
         end else if (pick < 72) begin
            push_word(CMD_REPORT, CHAN_WIDTH'($urandom_range(0, 15)), RAW_BITS'($urandom));
            made++;
         end else if (pick < 85) begin
            push_word(CMD_SAMPLE, CHAN_WIDTH'($urandom_range(0, NUM_CHANNELS - 1)),
                      pick_raw());
            made++;
         end else begin
            push_word(CMD_SAMPLE, CHAN_WIDTH'($urandom_range(NUM_CHANNELS, 15)),
                      RAW_BITS'($urandom));
            made++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: empty report, extremes, dropped channels, repeated report.
      push_word(CMD_REPORT, 4'd0, 16'h0000);
      push_word(CMD_SAMPLE, 4'd0, 16'h0000);
      push_word(CMD_SAMPLE, 4'd0, 16'hFFFF);
      push_word(CMD_SAMPLE, 4'd11, 16'h0001);
      push_word(CMD_SAMPLE, 4'd12, 16'hAAAA);
      push_word(CMD_SAMPLE, 4'd15, 16'h5555);
      push_word(CMD_REPORT, 4'd15, 16'hFFFF);
      push_word(CMD_REPORT, 4'd3, 16'h1234);
      settle();

      // Half gain with a zero limit: nothing accumulates.
      configure(4'd0, 16'd0);
      push_word(CMD_SAMPLE, 4'd3, 16'hFFFF);
      push_word(CMD_SAMPLE, 4'd11, 16'h0001);
      push_word(CMD_REPORT, 4'd0, 16'h0000);
      settle();

      // Gain code above the top saturates; widest limit.
      configure(4'd15, 16'hFFFF);
      push_word(CMD_SAMPLE, 4'd11, 16'hFFFF);
      push_word(CMD_SAMPLE, 4'd7, 16'h8000);
      push_word(CMD_REPORT, 4'd0, 16'h0000);
      settle();

      // Top gain exactly, limit lowered below the sweep count.
      configure(GAIN_MAX, 16'd1);
      push_word(CMD_SAMPLE, 4'd2, 16'h1234);
      push_word(CMD_REPORT, 4'd0, 16'h0000);
      settle();

      // Unity gain.
      configure(4'd1, 16'hFFFF);
      push_word(CMD_SAMPLE, 4'd4, 16'hFFFF);
      settle();

      // Random part in three idling modes, each over several register settings.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int part = 0; part < 3; part++) begin
            configure(GAIN_WIDTH'($urandom_range(0, 15)), pick_limit());
            if (mode == 0 && part == 0) hold_armed = 1'b1;
            queue_random_words(25);
            settle();
         end
      end

      if (mismatches == 0) begin
         $display("spectral_channel_statistics_core regression: pass");
      end else begin
         $display("spectral_channel_statistics_core regression: fail");
      end
      $finish;
   end

endmodule
